@@ hdl/bmorph_pkg.sv @@
package bmorph_pkg;

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 25;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Register indexes on the configuration port.
  localparam cfg_idx_t REG_IMAGE_WIDTH  = 3'd0;
  localparam cfg_idx_t REG_IMAGE_HEIGHT = 3'd1;
  localparam cfg_idx_t REG_BIN_THRESH   = 3'd2;
  localparam cfg_idx_t REG_OP_MODE      = 3'd3;
  localparam cfg_idx_t REG_SE_MASK      = 3'd4;

  // Register widths.
  localparam int WIDTH_W  = 11;
  localparam int HEIGHT_W = 12;
  localparam int GRAY_W   = 8;
  localparam int MASK_W   = 25;

  // Morphology operations.
  localparam logic OP_EROSION  = 1'b0;
  localparam logic OP_DILATION = 1'b1;

  // Register values after reset.
  localparam logic [WIDTH_W-1:0]  RST_IMAGE_WIDTH  = 11'd640;
  localparam logic [HEIGHT_W-1:0] RST_IMAGE_HEIGHT = 12'd480;
  localparam logic [GRAY_W-1:0]   RST_BIN_THRESH   = 8'd150;
  localparam logic                RST_OP_MODE      = OP_EROSION;
  localparam logic [MASK_W-1:0]   RST_SE_MASK      = 25'd4357252;

endpackage

@@ hdl/bmorph_line_mem.sv @@
module bmorph_line_mem #(
  parameter int DEPTH = 1024,
  parameter int DW    = 4,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_data_i,
  output logic [DW-1:0] rd_data_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_q;
  logic [DW-1:0] byp_data_q;
  logic          byp_q;

  // Single-port-write, single-port-read storage with a registered read.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q       <= mem[rd_addr_i];
      byp_data_q <= wr_data_i;
    end
  end

  // A read that collides with a write to the same column takes the new data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else if (rd_en_i) begin
      byp_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign rd_data_o = byp_q ? byp_data_q : rd_q;

endmodule

@@ hdl/binary_morphology_5x5.sv @@
// Binary erosion or dilation with a programmable SE_SIZE x SE_SIZE structuring
// element on a raster stream of gray pixels. Each pixel is binarized (foreground
// when strictly above the threshold) and every accepted transaction yields one
// result transaction: the morphology output for the pixel HALF*width+HALF
// positions earlier, with out_valid low while that position lies before the
// frame start and out_pixel low on the image border. The block takes one pixel
// per clock while the result output is not stalled; a result passes from
// stage one, which holds it while the line-store memory that keeps SE_SIZE-1
// binary rows per column is read, into the output register. Configuration
// must be written only while the block is idle; the block itself does not
// enforce this. The line store needs no clearing after reset.
module binary_morphology_5x5
  import bmorph_pkg::*;
#(
  parameter int MAX_WIDTH = 1024,
  parameter int SE_SIZE   = 5
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // Pixel input channel
  input  logic                  pix_valid_i,
  output logic                  pix_stall_o,
  input  logic [GRAY_W-1:0]     gray_pixel_i,
  input  logic                  frame_start_i,
  // Result output channel
  output logic                  res_valid_o,
  input  logic                  res_stall_i,
  output logic                  out_pixel_o,
  output logic                  out_valid_o
);

  localparam int HALF = SE_SIZE / 2;
  localparam int LSW  = SE_SIZE - 1;
  localparam int WIN  = SE_SIZE * SE_SIZE;
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int WEW  = CW + 1;

  // Configuration registers
  logic [WIDTH_W-1:0]  cfg_width_q;
  logic [HEIGHT_W-1:0] cfg_height_q;
  logic [GRAY_W-1:0]   cfg_thresh_q;
  logic                cfg_mode_q;
  logic [MASK_W-1:0]   cfg_mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= RST_IMAGE_WIDTH;
      cfg_height_q <= RST_IMAGE_HEIGHT;
      cfg_thresh_q <= RST_BIN_THRESH;
      cfg_mode_q   <= RST_OP_MODE;
      cfg_mask_q   <= RST_SE_MASK;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_IMAGE_WIDTH:  cfg_width_q  <= cfg_wdata_i[WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: cfg_height_q <= cfg_wdata_i[HEIGHT_W-1:0];
        REG_BIN_THRESH:   cfg_thresh_q <= cfg_wdata_i[GRAY_W-1:0];
        REG_OP_MODE:      cfg_mode_q   <= cfg_wdata_i[0];
        REG_SE_MASK:      cfg_mask_q   <= cfg_wdata_i[MASK_W-1:0];
        default:          ;
      endcase
    end
  end

  // Effective image size after clamping.
  logic [WEW-1:0]      w_eff;
  logic [HEIGHT_W-1:0] h_eff;

  always_comb begin
    if (32'(cfg_width_q) > 32'(MAX_WIDTH)) begin
      w_eff = WEW'(MAX_WIDTH);
    end else if (32'(cfg_width_q) < 32'(SE_SIZE)) begin
      w_eff = WEW'(SE_SIZE);
    end else begin
      w_eff = WEW'(cfg_width_q);
    end
    if (32'(cfg_height_q) < 32'(SE_SIZE)) begin
      h_eff = HEIGHT_W'(SE_SIZE);
    end else begin
      h_eff = cfg_height_q;
    end
  end

  // Handshake: the output register frees stage one, stage one frees the input.
  logic res_valid_q;
  logic s1_v_q;
  logic out_ready;
  logic s1_go;
  logic pix_ready;
  logic pix_accept;

  assign out_ready   = !res_valid_q || !res_stall_i;
  assign s1_go       = s1_v_q && out_ready;
  assign pix_ready   = !s1_v_q || out_ready;
  assign pix_accept  = pix_valid_i && pix_ready;
  assign pix_stall_o = !pix_ready;

  // Raster position of the incoming pixel and of the one after it.
  logic [CW-1:0]       col_q;
  logic [HEIGHT_W-1:0] row_q;
  logic [CW-1:0]       cur_col;
  logic [HEIGHT_W-1:0] cur_row;
  logic [CW-1:0]       nxt_col;
  logic [HEIGHT_W-1:0] nxt_row;
  logic [HEIGHT_W:0]   row_pre_inc;
  logic [HEIGHT_W:0]   row_cur_inc;
  logic [WEW-1:0]      col_inc;
  logic [HEIGHT_W-1:0] row_tmp;

  always_comb begin
    row_pre_inc = {1'b0, row_q} + 1'b1;
    if (frame_start_i) begin
      cur_col = '0;
      row_tmp = '0;
    end else if ({1'b0, col_q} >= w_eff) begin
      cur_col = '0;
      row_tmp = (row_pre_inc >= {1'b0, h_eff}) ? '0 : row_pre_inc[HEIGHT_W-1:0];
    end else begin
      cur_col = col_q;
      row_tmp = row_q;
    end
    cur_row = (row_tmp >= h_eff) ? '0 : row_tmp;

    col_inc     = {1'b0, cur_col} + 1'b1;
    row_cur_inc = {1'b0, cur_row} + 1'b1;
    if (col_inc >= w_eff) begin
      nxt_col = '0;
      nxt_row = (row_cur_inc >= {1'b0, h_eff}) ? '0 : row_cur_inc[HEIGHT_W-1:0];
    end else begin
      nxt_col = col_inc[CW-1:0];
      nxt_row = cur_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (pix_accept) begin
      col_q <= nxt_col;
      row_q <= nxt_row;
    end
  end

  // Position tests: the delayed pixel lies at or after the frame start, and
  // the window lies fully inside the image.
  logic cur_vld;
  logic cur_inner;

  assign cur_vld   = (32'(cur_row) > 32'(HALF))
                  || ((32'(cur_row) == 32'(HALF)) && (32'(cur_col) >= 32'(HALF)));
  assign cur_inner = (32'(cur_row) >= 32'(2 * HALF)) && (32'(cur_col) >= 32'(2 * HALF));

  // Stage one holds the transaction while its line-store column is read.
  logic [CW-1:0] s1_col_q;
  logic          s1_bit_q;
  logic          s1_vld_q;
  logic          s1_inner_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (pix_ready) begin
      s1_v_q <= pix_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_accept) begin
      s1_col_q   <= cur_col;
      s1_bit_q   <= gray_pixel_i > cfg_thresh_q;
      s1_vld_q   <= cur_vld;
      s1_inner_q <= cur_inner;
    end
  end

  // Line store: SE_SIZE-1 binary rows per column, bit 0 the row just above.
  logic [LSW-1:0] ls_old;
  logic [LSW-1:0] ls_new;

  assign ls_new = {ls_old[LSW-2:0], s1_bit_q};

  bmorph_line_mem #(
    .DEPTH (MAX_WIDTH),
    .DW    (LSW)
  ) u_line_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (pix_accept),
    .rd_addr_i (cur_col),
    .wr_en_i   (s1_go),
    .wr_addr_i (s1_col_q),
    .wr_data_i (ls_new),
    .rd_data_o (ls_old)
  );

  // Window shifts one column left; the new right column is the stored rows
  // (oldest on top) with the current pixel at the bottom.
  logic [WIN-1:0] win_q;
  logic [WIN-1:0] win_d;

  always_comb begin
    for (int r = 0; r < SE_SIZE; r++) begin
      for (int c = 0; c < SE_SIZE; c++) begin
        if (c < SE_SIZE - 1) begin
          win_d[r*SE_SIZE+c] = win_q[r*SE_SIZE+c+1];
        end else if (r < SE_SIZE - 1) begin
          win_d[r*SE_SIZE+c] = ls_old[SE_SIZE-2-r];
        end else begin
          win_d[r*SE_SIZE+c] = s1_bit_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (s1_go) begin
      win_q <= win_d;
    end
  end

  // Morphology decision on the updated window.
  logic [WIN-1:0] se_act;
  logic           morph_bit;

  assign se_act = cfg_mask_q[WIN-1:0];

  always_comb begin
    if (cfg_mode_q == OP_DILATION) begin
      morph_bit = |(se_act & win_d);
    end else begin
      morph_bit = ~|(se_act & ~win_d);
    end
  end

  // Output register.
  logic out_pixel_q;
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (out_ready) begin
      res_valid_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      out_valid_q <= s1_vld_q;
      out_pixel_q <= s1_vld_q && s1_inner_q && morph_bit;
    end
  end

  assign res_valid_o = res_valid_q;
  assign out_pixel_o = out_pixel_q;
  assign out_valid_o = out_valid_q;

  // A set result pixel is always marked valid.
  a_pixel_needs_valid: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (out_valid_o || !out_pixel_o)
  ) else $error("result pixel set while its position is not valid");

  // A stalled stage one blocks new input transactions.
  a_s1_blocks_input: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && !out_ready) |-> !pix_accept
  ) else $error("input accepted while stage one is held");

  // The first pixel of a frame lies before the delayed position.
  a_frame_start_invalid: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (pix_accept && frame_start_i) |=> (s1_v_q && !s1_vld_q && s1_col_q == '0)
  ) else $error("frame start not placed at the origin");

  // Every accepted transaction reaches stage one.
  a_accept_fills_s1: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    pix_accept |=> s1_v_q
  ) else $error("accepted transaction lost before stage one");

endmodule
